@@ src/nbd_pkg.sv @@
// shared types and constants for the nsec type bitmap decoder
// no dependencies; imported by every module of the block

package nbd_pkg;

  localparam int ByteW      = 8;
  localparam int LenW       = 16;
  localparam int TypeW      = 17;
  localparam int InTdataW   = 24;
  localparam int OutTdataW  = 24;
  localparam int BitsPerMap = 8;

  // one unit of work passed from the front to the back
  typedef struct packed {
    logic             corrupt;
    logic [TypeW-1:0] base;
    logic [ByteW-1:0] bits;
  } nbd_job_t;

  // one result item leaving the back
  typedef struct packed {
    logic [TypeW-1:0] type_number;
    logic             corrupt;
    logic             last;
  } nbd_result_t;

endpackage

@@ src/nbd_front.sv @@
// front end: walks the window / length / bitmap structure one byte a cycle while in_valid_i holds
// depends on nbd_pkg; emits jobs for the back end through the queue

module nbd_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [nbd_pkg::ByteW-1:0] data_byte_i,
  input  logic                     start_req_i,
  input  logic [nbd_pkg::LenW-1:0]  field_length_i,
  output logic                     push_o,
  output nbd_pkg::nbd_job_t        job_o
);
  import nbd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WIN,
    PH_LEN,
    PH_MAP
  } phase_e;

  phase_e           phase_q, phase_d, phase_s;
  logic [LenW-1:0]  rem_q, rem_d, rem_s;
  logic [TypeW-1:0] ntype_q, ntype_d, ntype_s;
  logic [ByteW-1:0] mbl_q, mbl_d, mbl_s;
  logic [LenW-1:0]  rem_dec, rem_left;

  // a start always opens a fresh field before the byte is looked at
  always_comb begin
    if (start_req_i) begin
      rem_s   = field_length_i;
      ntype_s = '0;
      mbl_s   = '0;
      phase_s = (field_length_i > LenW'(1)) ? PH_WIN : PH_IDLE;
    end else begin
      rem_s   = rem_q;
      ntype_s = ntype_q;
      mbl_s   = mbl_q;
      phase_s = phase_q;
    end
  end

  // per-byte decode
  always_comb begin
    phase_d  = phase_s;
    rem_d    = rem_s;
    ntype_d  = ntype_s;
    mbl_d    = mbl_s;
    push_o   = 1'b0;
    job_o    = '0;
    rem_dec  = rem_s - LenW'(1);
    rem_left = rem_dec - LenW'(data_byte_i);
    unique case (phase_s)
      PH_WIN: begin
        ntype_d = {1'b0, data_byte_i, 8'h00};
        rem_d   = rem_dec;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        rem_d = rem_dec;
        if (LenW'(data_byte_i) > rem_dec) begin
          // map length overruns the field
          push_o       = in_valid_i;
          job_o.corrupt = 1'b1;
          phase_d      = PH_IDLE;
        end else begin
          rem_d = rem_left;
          mbl_d = data_byte_i;
          if (data_byte_i == '0) begin
            phase_d = (rem_left > LenW'(1)) ? PH_WIN : PH_IDLE;
          end else begin
            phase_d = PH_MAP;
          end
        end
      end
      PH_MAP: begin
        push_o     = in_valid_i && (data_byte_i != '0);
        job_o.base = ntype_s;
        job_o.bits = data_byte_i;
        ntype_d    = ntype_s + TypeW'(BitsPerMap);
        mbl_d      = mbl_s - ByteW'(1);
        if (mbl_s == ByteW'(1)) begin
          phase_d = (rem_s > LenW'(1)) ? PH_WIN : PH_IDLE;
        end
      end
      PH_IDLE: begin
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // state update on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rem_q   <= '0;
      ntype_q <= '0;
      mbl_q   <= '0;
    end else if (in_valid_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      ntype_q <= ntype_d;
      mbl_q   <= mbl_d;
    end
  end

endmodule

@@ src/nbd_queue.sv @@
// short job queue between front and back, show-ahead read
// depends on nbd_pkg for the job type

module nbd_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  nbd_pkg::nbd_job_t job_i,
  input  logic              pop_i,
  output nbd_pkg::nbd_job_t job_o,
  output logic              empty_o,
  output logic              full_o
);
  import nbd_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  nbd_job_t        mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(DEPTH));
  assign job_o   = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ src/nbd_back.sv @@
// back end: expands one job into results, one set bit per cycle while the output register is free
// depends on nbd_pkg; drives the registered output stage

module nbd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nbd_pkg::nbd_job_t   job_i,
  input  logic                job_valid_i,
  output logic                pop_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output nbd_pkg::nbd_result_t out_o
);
  import nbd_pkg::*;

  logic             cur_valid_q;
  logic             cur_corrupt_q;
  logic [TypeW-1:0] cur_base_q;
  logic [ByteW-1:0] cur_bits_q;
  logic             out_valid_q;
  nbd_result_t      out_q, res_d;
  logic [2:0]       pos;
  logic [ByteW-1:0] bits_left;
  logic             out_free, emit, done, load;

  // highest set bit is the lowest type number
  always_comb begin
    pos = '0;
    for (int i = 0; i < BitsPerMap; i++) begin
      if (cur_bits_q[i]) begin
        pos = 3'(i);
      end
    end
  end

  // next result from the current job
  always_comb begin
    bits_left = cur_bits_q & ~(ByteW'(1) << pos);
    if (cur_corrupt_q) begin
      res_d.type_number = '0;
      res_d.corrupt     = 1'b1;
      res_d.last        = 1'b1;
    end else begin
      res_d.type_number = cur_base_q + TypeW'(3'd7 - pos);
      res_d.corrupt     = 1'b0;
      res_d.last        = (bits_left == '0);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = cur_valid_q && out_free;
  assign done     = emit && res_d.last;
  assign load     = job_valid_i && (!cur_valid_q || done);
  assign pop_o    = load;

  // current job register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
    end else if (load) begin
      cur_valid_q <= 1'b1;
    end else if (done) begin
      cur_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_corrupt_q <= job_i.corrupt;
      cur_base_q    <= job_i.base;
      cur_bits_q    <= job_i.bits;
    end else if (emit) begin
      cur_bits_q <= bits_left;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ src/nsec_type_bitmap_decoder.sv @@
// nsec type bitmap decoder top level
// path: a result reaches the master side through the queue, job and output registers
// throughput: one byte a cycle while m_axis_tready holds and each byte gives
// at most one result; a bitmap byte holds the expander until its set bits are out
// reset: asynchronous, active low; clears decode state, queue and output valid
// depends on nbd_pkg, nbd_front, nbd_queue and nbd_back

module nsec_type_bitmap_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [nbd_pkg::InTdataW-1:0]    s_axis_tdata,  // data_byte, field_length
  input  logic                            s_axis_tuser,  // start_req
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [nbd_pkg::OutTdataW-1:0]   m_axis_tdata,  // type_number, zero fill
  output logic                            m_axis_tuser,  // corrupt
  output logic                            m_axis_tlast   // last
);
  import nbd_pkg::*;

  logic        in_xfer, push, pop, q_empty, q_full;
  nbd_job_t    job_in, job_out;
  nbd_result_t res;

  assign s_axis_tready = !q_full;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // byte classification
  nbd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_xfer),
    .data_byte_i   (s_axis_tdata[ByteW-1:0]),
    .start_req_i   (s_axis_tuser),
    .field_length_i(s_axis_tdata[ByteW +: LenW]),
    .push_o        (push),
    .job_o         (job_in)
  );

  // decoupling queue
  nbd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_out),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  // result expansion
  nbd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job_out),
    .job_valid_i(!q_empty),
    .pop_o      (pop),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_o      (res)
  );

  assign m_axis_tdata = {(OutTdataW - TypeW)'(0), res.type_number};
  assign m_axis_tuser = res.corrupt;
  assign m_axis_tlast = res.last;

endmodule

@@ src/nbd_checker.sv @@
// port-level checks for the nsec type bitmap decoder
// depends on nbd_pkg; bound to the top level below

module nbd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [nbd_pkg::InTdataW-1:0]  s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [nbd_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);
  import nbd_pkg::*;

  // an error result is alone and carries no type
  a_corrupt_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("corrupt result without last or with a type number");

  // fill bits above the type number stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutTdataW-1:TypeW] == '0))
    else $error("tdata fill bits set");

  // nothing leaves while reset is held
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result shown during reset");

  // a stalled result keeps its valid
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn before transfer");

  // a stalled result keeps its payload
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed before transfer");

endmodule

bind nsec_type_bitmap_decoder nbd_checker u_nbd_checker (.*);
